// ===== sv/hart_frame_receiver_core_assert.svh =====
// assertion helpers shared by the frame receiver rtl
// every check is clocked on the rising edge and held off during reset
`ifndef HART_FRAME_RECEIVER_CORE_ASSERT_SVH
`define HART_FRAME_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication
`define HFR_ASSERT_IMP(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HFR_ASSERT_NXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hfr_pkg.sv =====
// ----------------------------------------------------------------------------
// hfr_pkg
// Types, codes and constants of the frame receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

    localparam int HFR_BUFFER_BYTES       = 267;
    localparam int HFR_LONG_ADDRESS_BYTES = 5;

    localparam int HFR_CFG_INDEX_W = 3;
    localparam int HFR_CFG_DATA_W  = 24;

    typedef enum logic [HFR_CFG_INDEX_W-1:0] {
        CFG_POLL_ADDRESS  = 3'd0,
        CFG_DEVICE_TYPE   = 3'd1,
        CFG_DEVICE_ID     = 3'd2,
        CFG_MIN_PREAMBLES = 3'd3,
        CFG_MAX_PREAMBLES = 3'd4
    } cfg_index_t;

    localparam logic [4:0] HFR_MIN_PREAMBLES_RST = 5'd2;
    localparam logic [4:0] HFR_MAX_PREAMBLES_RST = 5'd30;

    localparam logic [7:0] HFR_PREAMBLE    = 8'hFF;
    localparam logic [7:0] HFR_DELIM_MASK  = 8'h67;
    localparam logic [7:0] HFR_DELIM_CODE  = 8'h02;

    // error flag bit positions
    localparam int ERR_BAD_LRC   = 0;
    localparam int ERR_FRAMING   = 1;
    localparam int ERR_OVERRUN   = 2;
    localparam int ERR_PARITY    = 3;
    localparam int ERR_EXCESS_PA = 4;
    localparam int ERR_SHORT_PA  = 5;
    localparam int ERR_STX       = 6;
    localparam int ERR_EXTRA     = 7;

    localparam logic [7:0] HFR_ERR_RESET = 8'h01;

    // match flag bit positions
    localparam int MF_VALID = 0;
    localparam int MF_BCAST = 1;
    localparam int MF_PRIM  = 2;
    localparam int MF_LRCOK = 3;
    localparam int MF_FRAME = 4;

    typedef enum logic [1:0] {
        FS_HUNT     = 2'd0,
        FS_IN_FRAME = 2'd1,
        FS_COMPLETE = 2'd2,
        FS_ABORTED  = 2'd3
    } frame_state_t;

    typedef enum logic [1:0] {
        TMR_NONE        = 2'd0,
        TMR_GAP_START   = 2'd1,
        TMR_REPLY_START = 2'd2,
        TMR_REPLY_STOP  = 2'd3
    } timer_event_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic       parity_error;
        logic       framing_error;
        logic       overrun_error;
    } hfr_item_t;

    typedef struct packed {
        logic [1:0] frame_state;
        logic [7:0] error_flags;
        logic       command_ready;
        logic       frame_received;
        logic       lrc_ok;
        logic       address_valid;
        logic       broadcast;
        logic       from_primary;
        logic       store_valid;
        logic [8:0] store_index;
        logic [7:0] store_byte;
        logic [1:0] timer_event;
    } hfr_result_t;

    typedef struct packed {
        logic [5:0]  poll_address;
        logic [13:0] device_type;
        logic [23:0] device_id;
        logic [4:0]  min_preambles;
        logic [4:0]  max_preambles;
    } hfr_cfg_t;

endpackage

// ===== sv/hfr_stream_if.sv =====
// ----------------------------------------------------------------------------
// hfr_stream_if
// Valid/ready channels for received bytes and for results.
// ----------------------------------------------------------------------------
interface hfr_item_if import hfr_pkg::*; ();
    logic      valid;
    logic      ready;
    hfr_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hfr_result_if import hfr_pkg::*; ();
    logic        valid;
    logic        ready;
    hfr_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hfr_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// hfr_frame_fsm
// Frame state, address store and per-byte decode; state advances on step.
// ----------------------------------------------------------------------------
`include "hart_frame_receiver_core_assert.svh"

module hfr_frame_fsm
    import hfr_pkg::*;
#(
    parameter int BUFFER_BYTES = HFR_BUFFER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  hfr_cfg_t    cfg,
    input  logic        step,
    input  hfr_item_t   item,
    output hfr_result_t res
);

    localparam int WPOS_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [WPOS_W-1:0] BUF_LIMIT = WPOS_W'(BUFFER_BYTES);
    localparam int ACNT_W = 3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_CMD,
        PH_BCNT,
        PH_DATA,
        PH_LRC,
        PH_XTRA
    } phase_t;

    phase_t              phase_reg,  phase_next;
    logic [4:0]          pre_reg,    pre_next;
    logic [ACNT_W-1:0]   acnt_reg,   acnt_next;
    logic                long_reg,   long_next;
    logic [7:0]          exp_reg,    exp_next;
    logic [7:0]          dcnt_reg,   dcnt_next;
    logic [7:0]          lrc_reg,    lrc_next;
    logic [WPOS_W-1:0]   wpos_reg,   wpos_next;
    logic [7:0]          err_reg,    err_next;
    logic [4:0]          mf_reg,     mf_next;

    logic [7:0] addr_mem [HFR_LONG_ADDRESS_BYTES];
    logic [7:0] addr_view [HFR_LONG_ADDRESS_BYTES];
    logic       addr_we;

    logic [13:0] addr_type;
    logic [23:0] addr_id;
    logic        long_hit;
    logic        bcast_hit;
    logic        short_hit;

    logic       line_err;
    logic       abort_frame;
    logic       to_hunt;
    logic       store;
    logic       cmd_pulse;
    logic [1:0] timer;
    logic [7:0] b;

    assign b        = item.rx_byte;
    assign line_err = item.parity_error | item.framing_error | item.overrun_error;

    // address bytes as they stand once this byte is written
    always_comb
    begin
        for (int i = 0; i < HFR_LONG_ADDRESS_BYTES; i++)
        begin
            addr_view[i] = (acnt_reg == ACNT_W'(i)) ? b : addr_mem[i];
        end
    end

    assign addr_type = {addr_view[0][5:0], addr_view[1]};
    assign addr_id   = {addr_view[2], addr_view[3], addr_view[4]};
    assign short_hit = (addr_view[0][5:0] == cfg.poll_address);
    assign long_hit  = (addr_type == cfg.device_type) && (addr_id == cfg.device_id);
    assign bcast_hit = (addr_type == 14'd0) && (addr_id == 24'd0);

    always_comb
    begin
        phase_next  = phase_reg;
        pre_next    = pre_reg;
        acnt_next   = acnt_reg;
        long_next   = long_reg;
        exp_next    = exp_reg;
        dcnt_next   = dcnt_reg;
        lrc_next    = lrc_reg;
        wpos_next   = wpos_reg;
        err_next    = err_reg;
        mf_next     = mf_reg;
        abort_frame = 1'b0;
        to_hunt     = 1'b0;
        store       = 1'b0;
        cmd_pulse   = 1'b0;
        timer       = TMR_NONE;
        addr_we     = 1'b0;
        res         = '0;

        if (item.kind)
        begin
            res.frame_state = FS_HUNT;
            res.error_flags = HFR_ERR_RESET;
            res.timer_event = TMR_REPLY_STOP;
        end
        else
        begin
            if (item.framing_error)
                err_next[ERR_FRAMING] = 1'b1;
            if (item.overrun_error && phase_reg != PH_HUNT)
                err_next[ERR_OVERRUN] = 1'b1;
            if (item.parity_error)
                err_next[ERR_PARITY] = 1'b1;

            case (phase_reg)
                PH_HUNT:
                begin
                    if (item.parity_error || item.framing_error)
                        abort_frame = 1'b1;
                    else if (b == HFR_PREAMBLE)
                    begin
                        if (pre_reg >= cfg.max_preambles)
                        begin
                            err_next[ERR_EXCESS_PA] = 1'b1;
                            abort_frame = 1'b1;
                        end
                        else
                            pre_next = pre_reg + 5'd1;
                    end
                    else if ((b & HFR_DELIM_MASK) == HFR_DELIM_CODE)
                    begin
                        if (pre_reg < cfg.min_preambles)
                        begin
                            err_next[ERR_SHORT_PA] = 1'b1;
                            abort_frame = 1'b1;
                        end
                        else
                        begin
                            long_next  = b[7];
                            acnt_next  = '0;
                            phase_next = PH_ADDR;
                            timer      = TMR_GAP_START;
                            store      = 1'b1;
                        end
                    end
                    else
                    begin
                        err_next[ERR_STX] = 1'b1;
                        abort_frame = 1'b1;
                    end
                end
                PH_ADDR:
                begin
                    if (line_err)
                        abort_frame = 1'b1;
                    else
                    begin
                        addr_we   = (acnt_reg < ACNT_W'(HFR_LONG_ADDRESS_BYTES));
                        acnt_next = acnt_reg + ACNT_W'(1);
                        store     = 1'b1;
                        if (acnt_next >= (long_reg ? ACNT_W'(HFR_LONG_ADDRESS_BYTES)
                                                   : ACNT_W'(1)))
                        begin
                            phase_next         = PH_CMD;
                            mf_next[MF_VALID]  = 1'b0;
                            mf_next[MF_BCAST]  = 1'b0;
                            mf_next[MF_PRIM]   = addr_view[0][7];
                            if (!long_reg)
                                mf_next[MF_VALID] = short_hit;
                            else if (long_hit)
                                mf_next[MF_VALID] = 1'b1;
                            else if (bcast_hit)
                            begin
                                mf_next[MF_VALID] = 1'b1;
                                mf_next[MF_BCAST] = 1'b1;
                            end
                        end
                    end
                end
                PH_CMD:
                begin
                    phase_next = PH_BCNT;
                    err_next[ERR_BAD_LRC] = 1'b1;
                    cmd_pulse  = mf_reg[MF_VALID];
                    store      = 1'b1;
                end
                PH_BCNT:
                begin
                    if (line_err)
                        abort_frame = 1'b1;
                    else
                    begin
                        exp_next   = b;
                        dcnt_next  = '0;
                        phase_next = (b != 8'd0) ? PH_DATA : PH_LRC;
                        store      = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    dcnt_next = dcnt_reg + 8'd1;
                    if (dcnt_next == exp_reg)
                        phase_next = PH_LRC;
                    store = 1'b1;
                end
                PH_LRC:
                begin
                    timer = TMR_REPLY_START;
                    if (lrc_reg == b)
                    begin
                        err_next[ERR_BAD_LRC] = 1'b0;
                        mf_next[MF_LRCOK]     = 1'b1;
                    end
                    else
                    begin
                        err_next[ERR_BAD_LRC] = 1'b1;
                        mf_next[MF_LRCOK]     = 1'b0;
                    end
                    if (mf_reg[MF_VALID])
                    begin
                        mf_next[MF_FRAME] = 1'b1;
                        phase_next        = PH_XTRA;
                    end
                    else
                        to_hunt = 1'b1;
                    store = 1'b1;
                end
                default:
                begin
                    err_next[ERR_EXTRA] = 1'b1;
                    store = 1'b1;
                end
            endcase

            if (store)
            begin
                if (wpos_reg < BUF_LIMIT)
                begin
                    res.store_valid = 1'b1;
                    res.store_index = 9'(wpos_reg);
                    res.store_byte  = b;
                    wpos_next       = wpos_reg + WPOS_W'(1);
                end
                lrc_next = lrc_reg ^ b;
            end

            if (abort_frame)
            begin
                res.frame_state = FS_ABORTED;
                timer           = TMR_REPLY_STOP;
            end
            else if (to_hunt || phase_next == PH_HUNT)
                res.frame_state = FS_HUNT;
            else if (phase_next == PH_XTRA)
                res.frame_state = FS_COMPLETE;
            else
                res.frame_state = FS_IN_FRAME;

            res.error_flags    = err_next;
            res.command_ready  = cmd_pulse;
            res.frame_received = mf_next[MF_FRAME];
            res.lrc_ok         = mf_next[MF_LRCOK];
            res.address_valid  = mf_next[MF_VALID];
            res.broadcast      = mf_next[MF_BCAST];
            res.from_primary   = mf_next[MF_PRIM];
            res.timer_event    = timer;
        end

        if (item.kind || abort_frame || to_hunt)
        begin
            phase_next = PH_HUNT;
            pre_next   = '0;
            acnt_next  = '0;
            long_next  = 1'b0;
            exp_next   = '0;
            dcnt_next  = '0;
            lrc_next   = '0;
            wpos_next  = '0;
            err_next   = HFR_ERR_RESET;
            mf_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pre_reg   <= '0;
            acnt_reg  <= '0;
            long_reg  <= 1'b0;
            exp_reg   <= '0;
            dcnt_reg  <= '0;
            lrc_reg   <= '0;
            wpos_reg  <= '0;
            err_reg   <= HFR_ERR_RESET;
            mf_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pre_reg   <= pre_next;
            acnt_reg  <= acnt_next;
            long_reg  <= long_next;
            exp_reg   <= exp_next;
            dcnt_reg  <= dcnt_next;
            lrc_reg   <= lrc_next;
            wpos_reg  <= wpos_next;
            err_reg   <= err_next;
            mf_reg    <= mf_next;
        end
    end

    // address bytes hold no reset value
    always_ff @(posedge clk)
    begin
        if (step && addr_we)
            addr_mem[acnt_reg] <= b;
    end

    `HFR_ASSERT_IMP(a_hunt_no_position, clk, rst_n, phase_reg == PH_HUNT, wpos_reg == '0,
        "buffer position not cleared while hunting")
    `HFR_ASSERT_IMP(a_hunt_no_lrc, clk, rst_n, phase_reg == PH_HUNT, lrc_reg == 8'd0,
        "running lrc not cleared while hunting")
    `HFR_ASSERT_IMP(a_frame_in_extra, clk, rst_n, mf_reg[MF_FRAME], phase_reg == PH_XTRA,
        "frame received flag outside the extra phase")

endmodule

// ===== sv/hart_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// hart_frame_receiver_core
// Slave-side frame receiver: preamble, delimiter, address match, LRC check.
// ----------------------------------------------------------------------------
// item channel: one transaction per received UART byte with its line error
// flags, or a restart (kind set) that sends the receiver back to hunting.
// result channel: one transaction per item with frame state, error flags,
// address match results, a buffer store request and a timer event.
// cfg_we/cfg_index/cfg_wdata write the poll address, device type, device id
// and preamble limits; write them only while no transaction is in flight.
// a byte accepted into the input register is decoded there, and its result
// is loaded into the result register once that register is free or being
// read. throughput: one item per cycle while results are taken, set by the
// single decode stage between the input and result registers.
// a stalled result register holds; the input register fills behind it and
// ready drops only when both are occupied.
// reset: receiver hunting, error flags at bad lrc only, limits at 2 and 30,
// address and id registers at zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "hart_frame_receiver_core_assert.svh"

module hart_frame_receiver_core
    import hfr_pkg::*;
#(
    parameter int BUFFER_BYTES = HFR_BUFFER_BYTES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [HFR_CFG_INDEX_W-1:0] cfg_index,
    input  logic [HFR_CFG_DATA_W-1:0]  cfg_wdata,
    hfr_item_if.sink                   item,
    hfr_result_if.source               result
);

    hfr_cfg_t    cfg_reg;
    hfr_item_t   item_reg;
    logic        item_valid_reg;
    hfr_result_t res_reg;
    logic        res_valid_reg;
    hfr_result_t res_next;
    logic        advance;

    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready   = !item_valid_reg || advance;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_address  <= '0;
            cfg_reg.device_type   <= '0;
            cfg_reg.device_id     <= '0;
            cfg_reg.min_preambles <= HFR_MIN_PREAMBLES_RST;
            cfg_reg.max_preambles <= HFR_MAX_PREAMBLES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLL_ADDRESS:  cfg_reg.poll_address  <= cfg_wdata[5:0];
                CFG_DEVICE_TYPE:   cfg_reg.device_type   <= cfg_wdata[13:0];
                CFG_DEVICE_ID:     cfg_reg.device_id     <= cfg_wdata[23:0];
                CFG_MIN_PREAMBLES: cfg_reg.min_preambles <= cfg_wdata[4:0];
                CFG_MAX_PREAMBLES: cfg_reg.max_preambles <= cfg_wdata[4:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            item_reg <= item.data;
        if (advance)
            res_reg <= res_next;
    end

    hfr_frame_fsm #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (advance),
        .item  (item_reg),
        .res   (res_next)
    );

    `HFR_ASSERT_NXT(a_advance_loads, clk, rst_n, advance, res_valid_reg,
        "decoded transaction did not reach the result register")
    `HFR_ASSERT_IMP(a_store_in_range, clk, rst_n, res_valid_reg && res_reg.store_valid,
        res_reg.store_index < 9'(BUFFER_BYTES), "store index beyond buffer")
    `HFR_ASSERT_IMP(a_abort_stops_timer, clk, rst_n,
        res_valid_reg && res_reg.frame_state == FS_ABORTED,
        res_reg.timer_event == TMR_REPLY_STOP, "abort without reply timer stop")

endmodule
